// ===== rtl/core/ocp_pkg.sv =====
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types, constants, microcode and angle helpers for the orbit camera
// position block.
// ----------------------------------------------------------------------------
package ocp_pkg;

   // fixed-point setup
   localparam int TRIG_FRAC_BITS = 15;
   localparam int DIST_FRAC_BITS = 8;

   // field widths
   localparam int MODE_W     = 3;
   localparam int DX_W       = 12;
   localparam int DY_W       = 12;
   localparam int WHEEL_W    = 9;
   localparam int ANG_W      = 9;
   localparam int DIST_W     = 20;
   localparam int FOV_W      = 8;
   localparam int POS_W      = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // derived widths
   localparam int TRIG_MAG_W = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int PROD_W     = POS_W + TRIG_W;
   localparam int ZOOM_W     = ((DIST_W + 1 > DY_W + DIST_FRAC_BITS) ?
                                (DIST_W + 1) : (DY_W + DIST_FRAC_BITS)) + 1;
   localparam int TRIG_UP    = (TRIG_FRAC_BITS >= 15) ? (TRIG_FRAC_BITS - 15) : 0;
   localparam int TRIG_DN    = (TRIG_FRAC_BITS < 15) ? (15 - TRIG_FRAC_BITS) : 0;
   localparam int TRIG_RND   = (TRIG_DN > 0) ? (1 << (TRIG_DN - 1)) : 0;

   localparam logic [DIST_W-1:0] DIST_MASK = {DIST_W{1'b1}};

   // command codes
   localparam logic [MODE_W-1:0] MODE_ROTATE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ZOOM   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FOV    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INVERT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UP_IS_Y       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTRAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_YAW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PITCH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DIST    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FOV       = 3'd7;

   function automatic logic [DIST_W-1:0] sat_dist(input int unsigned whole);
      logic [63:0] v;
      v = 64'(whole) << DIST_FRAC_BITS;
      return (v > 64'(DIST_MASK)) ? DIST_MASK : v[DIST_W-1:0];
   endfunction

   localparam logic [DIST_W-1:0]       RST_MIN_DIST   = sat_dist(1);
   localparam logic [DIST_W-1:0]       RST_MAX_DIST   = sat_dist(1500);
   localparam logic [DIST_W-1:0]       RST_START_DIST = sat_dist(10);
   localparam logic signed [ANG_W-1:0] RST_YAW        = 9'sd0;
   localparam logic signed [ANG_W-1:0] RST_PITCH      = 9'sd90;
   localparam logic [FOV_W-1:0]        RST_FOV        = 8'd45;

   localparam logic signed [ANG_W-1:0] PITCH_LO = 9'sd1;
   localparam logic signed [ANG_W-1:0] PITCH_HI = 9'sd179;

   // quarter-wave sine, Q1.15, one entry per degree
   localparam logic [15:0] SIN_Q15 [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   // table value rescaled to TRIG_FRAC_BITS, rounded half up when narrowing
   function automatic logic [TRIG_MAG_W-1:0] trig_mag(input logic [6:0] idx);
      logic [39:0] v;
      v = 40'(SIN_Q15[idx]);
      v = ((v + 40'(TRIG_RND)) >> TRIG_DN) << TRIG_UP;
      return v[TRIG_MAG_W-1:0];
   endfunction

   // sine of a whole-degree angle in -180..269
   function automatic logic signed [TRIG_W-1:0] trig_value(input logic signed [9:0] a);
      logic [8:0]            r;
      logic                  neg;
      logic [7:0]            q;
      logic [6:0]            idx;
      logic [TRIG_MAG_W-1:0] mag;
      logic signed [TRIG_W-1:0] m;
      r   = a[9] ? 9'(a + 10'sd360) : a[8:0];
      neg = (r >= 9'd180);
      q   = neg ? 8'(r - 9'd180) : r[7:0];
      idx = (q > 8'd90) ? 7'(8'd180 - q) : q[6:0];
      mag = trig_mag(idx);
      m   = $signed({1'b0, mag});
      return neg ? -m : m;
   endfunction

   // wraps into -180..179; input stays within -3060..2699
   function automatic logic signed [ANG_W-1:0] wrap_deg(input logic signed [13:0] a);
      logic [14:0]       r;
      logic signed [9:0] s;
      r = 15'($signed({a[13], a}) + 15'sd3060);
      if (r >= 15'd2880) r = r - 15'd2880;
      if (r >= 15'd1440) r = r - 15'd1440;
      if (r >= 15'd720)  r = r - 15'd720;
      if (r >= 15'd360)  r = r - 15'd360;
      s = $signed({1'b0, r[8:0]}) - 10'sd180;
      return s[ANG_W-1:0];
   endfunction

   // ---------------------------------------------------------------- microcode
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TRIG  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_A = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_B = 3'd3;
   localparam logic [STEP_W-1:0] STEP_MUL_C = 3'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_D = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;

   typedef enum logic [1:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_REQ,
      JMP_OUT_BUSY
   } ocp_jump_type;

   typedef enum logic [0:0] {
      OPA_DIST,
      OPA_T1
   } ocp_opa_type;

   typedef enum logic [1:0] {
      TRIG_SIN_YAW,
      TRIG_COS_YAW,
      TRIG_SIN_PITCH,
      TRIG_COS_PITCH
   } ocp_trig_type;

   typedef enum logic [1:0] {
      DST_T1,
      DST_X,
      DST_Y,
      DST_Z
   } ocp_dst_type;

   typedef struct packed {
      logic              accept;
      logic              load_trig;
      logic              mul_en;
      ocp_opa_type       opa;
      ocp_trig_type      opb_y;
      ocp_trig_type      opb_z;
      ocp_dst_type       dst_y;
      ocp_dst_type       dst_z;
      logic              emit;
      ocp_jump_type      jump;
      logic [STEP_W-1:0] jump_step;
      logic [STEP_W-1:0] next_step;
   } ocp_uword_type;

   typedef struct packed {
      logic req_valid;
      logic out_busy;
   } ocp_status_type;

   function automatic ocp_uword_type ucode(input logic [STEP_W-1:0] step);
      ocp_uword_type w;
      w = '{accept: 1'b0, load_trig: 1'b0, mul_en: 1'b0, opa: OPA_DIST,
            opb_y: TRIG_SIN_YAW, opb_z: TRIG_SIN_YAW, dst_y: DST_T1, dst_z: DST_T1,
            emit: 1'b0, jump: JMP_NEVER, jump_step: STEP_IDLE, next_step: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.accept    = 1'b1;
            w.jump      = JMP_NO_REQ;
            w.jump_step = STEP_IDLE;
            w.next_step = STEP_TRIG;
         end
         STEP_TRIG: begin
            w.load_trig = 1'b1;
            w.next_step = STEP_MUL_A;
         end
         STEP_MUL_A: begin
            w.mul_en    = 1'b1;
            w.opa       = OPA_DIST;
            w.opb_y     = TRIG_SIN_PITCH;
            w.opb_z     = TRIG_COS_YAW;
            w.dst_y     = DST_T1;
            w.dst_z     = DST_T1;
            w.next_step = STEP_MUL_B;
         end
         STEP_MUL_B: begin
            w.mul_en    = 1'b1;
            w.opa       = OPA_DIST;
            w.opb_y     = TRIG_COS_PITCH;
            w.opb_z     = TRIG_SIN_YAW;
            w.dst_y     = DST_Y;
            w.dst_z     = DST_Z;
            w.next_step = STEP_MUL_C;
         end
         STEP_MUL_C: begin
            w.mul_en    = 1'b1;
            w.opa       = OPA_T1;
            w.opb_y     = TRIG_SIN_YAW;
            w.opb_z     = TRIG_SIN_PITCH;
            w.dst_y     = DST_X;
            w.dst_z     = DST_X;
            w.next_step = STEP_MUL_D;
         end
         STEP_MUL_D: begin
            w.mul_en    = 1'b1;
            w.opa       = OPA_T1;
            w.opb_y     = TRIG_COS_YAW;
            w.opb_z     = TRIG_COS_PITCH;
            w.dst_y     = DST_Z;
            w.dst_z     = DST_Y;
            w.next_step = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit      = 1'b1;
            w.jump      = JMP_OUT_BUSY;
            w.jump_step = STEP_EMIT;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/orbit_camera_position.sv =====
// ----------------------------------------------------------------------------
// orbit_camera_position
// Orbit camera state (yaw, pitch, distance, fov) updated by one command per
// transaction, followed by the camera position on the orbit sphere.
// ----------------------------------------------------------------------------
// Sequence: the microcode walks idle (request accepted), trig lookup, four passes
//   through the single shared multiplier and the output load; a new transaction
//   is accepted only once the sequencer is back in idle.
// A waiting response does not block the sequencer until its output load step.
// Reset (synchronous): requests stalled while held; registers and camera state
//   take their reset values, sequencer returns to idle, no response pending.
module orbit_camera_position (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     csr_wr_en,
   input  logic [ocp_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [ocp_pkg::CSR_DATA_W-1:0]           csr_wdata,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [ocp_pkg::MODE_W-1:0]               req_mode,
   input  logic signed [ocp_pkg::DX_W-1:0]          req_dx,
   input  logic signed [ocp_pkg::DY_W-1:0]          req_dy,
   input  logic signed [ocp_pkg::WHEEL_W-1:0]       req_wheel,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [ocp_pkg::POS_W-1:0]         rsp_pos_x,
   output logic signed [ocp_pkg::POS_W-1:0]         rsp_pos_y,
   output logic signed [ocp_pkg::POS_W-1:0]         rsp_pos_z,
   output logic [ocp_pkg::FOV_W-1:0]                rsp_view_angle,
   output logic [ocp_pkg::DIST_W-1:0]               rsp_orbit_range
);

   // configuration registers
   logic                                up_is_y_ff;
   logic                                constrain_ff;
   logic [ocp_pkg::DIST_W-1:0]          min_dist_ff;
   logic [ocp_pkg::DIST_W-1:0]          max_dist_ff;
   logic signed [ocp_pkg::ANG_W-1:0]    start_yaw_ff;
   logic signed [ocp_pkg::ANG_W-1:0]    start_pitch_ff;
   logic [ocp_pkg::DIST_W-1:0]          start_dist_ff;
   logic [ocp_pkg::FOV_W-1:0]           max_fov_ff;

   // camera state
   logic signed [ocp_pkg::ANG_W-1:0]    yaw_ff,   yaw_in;
   logic signed [ocp_pkg::ANG_W-1:0]    pitch_ff, pitch_in;
   logic [ocp_pkg::DIST_W-1:0]          dist_ff,  dist_in;
   logic [ocp_pkg::FOV_W-1:0]           fov_ff,   fov_in;

   // datapath
   logic signed [ocp_pkg::TRIG_W-1:0]   sin_yaw_ff, cos_yaw_ff, sin_pitch_ff, cos_pitch_ff;
   logic signed [ocp_pkg::POS_W-1:0]    t1_ff, px_ff, py_ff, pz_ff;
   logic signed [ocp_pkg::POS_W-1:0]    opa;
   logic signed [ocp_pkg::TRIG_W-1:0]   opb;
   logic signed [ocp_pkg::PROD_W-1:0]   prod;
   logic signed [ocp_pkg::POS_W-1:0]    mul_res;
   ocp_pkg::ocp_trig_type               opb_sel;
   ocp_pkg::ocp_dst_type                dst_sel;

   // response register
   logic                                rsp_valid_ff;
   logic signed [ocp_pkg::POS_W-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [ocp_pkg::FOV_W-1:0]           rsp_fov_ff;
   logic [ocp_pkg::DIST_W-1:0]          rsp_dist_ff;

   ocp_pkg::ocp_uword_type              ctrl;
   ocp_pkg::ocp_status_type             status;
   logic                                req_fire;
   logic                                out_busy;
   logic                                emit_fire;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && ctrl.accept;
   assign emit_fire = ctrl.emit && !out_busy;
   assign req_stall = !ctrl.accept || reset;

   assign status.req_valid = req_valid;
   assign status.out_busy  = out_busy;

   ocp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // ------------------------------------------------------------ configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         up_is_y_ff     <= 1'b1;
         constrain_ff   <= 1'b1;
         min_dist_ff    <= ocp_pkg::RST_MIN_DIST;
         max_dist_ff    <= ocp_pkg::RST_MAX_DIST;
         start_yaw_ff   <= ocp_pkg::RST_YAW;
         start_pitch_ff <= ocp_pkg::RST_PITCH;
         start_dist_ff  <= ocp_pkg::RST_START_DIST;
         max_fov_ff     <= ocp_pkg::RST_FOV;
      end else if (csr_wr_en) begin
         case (csr_index)
            ocp_pkg::CSR_UP_IS_Y:      up_is_y_ff     <= csr_wdata[0];
            ocp_pkg::CSR_CONSTRAIN:    constrain_ff   <= csr_wdata[0];
            ocp_pkg::CSR_MIN_DISTANCE: min_dist_ff    <= csr_wdata[ocp_pkg::DIST_W-1:0];
            ocp_pkg::CSR_MAX_DISTANCE: max_dist_ff    <= csr_wdata[ocp_pkg::DIST_W-1:0];
            ocp_pkg::CSR_START_YAW:    start_yaw_ff   <= $signed(csr_wdata[ocp_pkg::ANG_W-1:0]);
            ocp_pkg::CSR_START_PITCH:  start_pitch_ff <= $signed(csr_wdata[ocp_pkg::ANG_W-1:0]);
            ocp_pkg::CSR_START_DIST:   start_dist_ff  <= csr_wdata[ocp_pkg::DIST_W-1:0];
            ocp_pkg::CSR_MAX_FOV:      max_fov_ff     <= csr_wdata[ocp_pkg::FOV_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ command apply
   always_comb begin
      logic signed [13:0]                p;
      logic signed [ocp_pkg::ZOOM_W-1:0] v;
      logic signed [10:0]                f;
      logic signed [10:0]                fmax;
      yaw_in   = yaw_ff;
      pitch_in = pitch_ff;
      dist_in  = dist_ff;
      fov_in   = fov_ff;
      p        = '0;
      v        = '0;
      f        = $signed({3'b000, fov_ff});
      fmax     = $signed({3'b000, max_fov_ff});
      case (req_mode)
         ocp_pkg::MODE_ROTATE: begin
            if (up_is_y_ff) begin
               yaw_in = ocp_pkg::wrap_deg(14'(yaw_ff) - 14'(req_dx));
               p      = 14'(pitch_ff) - 14'(req_dy);
               if (constrain_ff) begin
                  if (p < 14'(ocp_pkg::PITCH_LO)) p = 14'(ocp_pkg::PITCH_LO);
                  if (p > 14'(ocp_pkg::PITCH_HI)) p = 14'(ocp_pkg::PITCH_HI);
               end
               pitch_in = ocp_pkg::wrap_deg(p);
            end else begin
               yaw_in   = ocp_pkg::wrap_deg(14'(yaw_ff) + 14'(req_dy));
               pitch_in = ocp_pkg::wrap_deg(14'(pitch_ff) + 14'(req_dx));
            end
         end
         ocp_pkg::MODE_ZOOM: begin
            v = ocp_pkg::ZOOM_W'($signed({1'b0, dist_ff}))
              + (ocp_pkg::ZOOM_W'(req_dy) <<< ocp_pkg::DIST_FRAC_BITS);
            // min first, max last: max wins when the limits cross
            if (v < ocp_pkg::ZOOM_W'($signed({1'b0, min_dist_ff})))
               v = ocp_pkg::ZOOM_W'($signed({1'b0, min_dist_ff}));
            if (v > ocp_pkg::ZOOM_W'($signed({1'b0, max_dist_ff})))
               v = ocp_pkg::ZOOM_W'($signed({1'b0, max_dist_ff}));
            dist_in = v[ocp_pkg::DIST_W-1:0];
         end
         ocp_pkg::MODE_FOV: begin
            if (req_wheel != '0 && f >= 11'sd1 && f <= fmax)
               f = f - 11'(req_wheel);
            if (f < 11'sd1)
               f = 11'sd1;
            else if (f > fmax)
               f = fmax;
            fov_in = f[ocp_pkg::FOV_W-1:0];
         end
         ocp_pkg::MODE_INVERT: begin
            pitch_in = ocp_pkg::wrap_deg(-14'(pitch_ff));
         end
         ocp_pkg::MODE_START: begin
            yaw_in   = ocp_pkg::wrap_deg(14'(start_yaw_ff));
            pitch_in = ocp_pkg::wrap_deg(14'(start_pitch_ff));
            dist_in  = start_dist_ff;
            fov_in   = max_fov_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= ocp_pkg::RST_YAW;
         pitch_ff <= ocp_pkg::RST_PITCH;
         dist_ff  <= ocp_pkg::RST_START_DIST;
         fov_ff   <= ocp_pkg::RST_FOV;
      end else if (req_fire) begin
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         dist_ff  <= dist_in;
         fov_ff   <= fov_in;
      end
   end

   // ------------------------------------------------------------ trig and multiply
   always_ff @(posedge clock) begin
      if (ctrl.load_trig) begin
         sin_yaw_ff   <= ocp_pkg::trig_value(10'(yaw_ff));
         cos_yaw_ff   <= ocp_pkg::trig_value(10'(yaw_ff) + 10'sd90);
         sin_pitch_ff <= ocp_pkg::trig_value(10'(pitch_ff));
         cos_pitch_ff <= ocp_pkg::trig_value(10'(pitch_ff) + 10'sd90);
      end
   end

   assign opb_sel = up_is_y_ff ? ctrl.opb_y : ctrl.opb_z;
   assign dst_sel = up_is_y_ff ? ctrl.dst_y : ctrl.dst_z;

   always_comb begin
      opa = (ctrl.opa == ocp_pkg::OPA_DIST) ? $signed({1'b0, dist_ff}) : t1_ff;
      case (opb_sel)
         ocp_pkg::TRIG_SIN_YAW:   opb = sin_yaw_ff;
         ocp_pkg::TRIG_COS_YAW:   opb = cos_yaw_ff;
         ocp_pkg::TRIG_SIN_PITCH: opb = sin_pitch_ff;
         ocp_pkg::TRIG_COS_PITCH: opb = cos_pitch_ff;
         default:                 opb = sin_yaw_ff;
      endcase
      prod    = ocp_pkg::PROD_W'(opa) * ocp_pkg::PROD_W'(opb);
      // arithmetic shift is the floor of the scaled product
      mul_res = ocp_pkg::POS_W'(prod >>> ocp_pkg::TRIG_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         case (dst_sel)
            ocp_pkg::DST_T1: t1_ff <= mul_res;
            ocp_pkg::DST_X:  px_ff <= mul_res;
            ocp_pkg::DST_Y:  py_ff <= mul_res;
            ocp_pkg::DST_Z:  pz_ff <= mul_res;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_x_ff    <= px_ff;
         rsp_y_ff    <= py_ff;
         rsp_z_ff    <= pz_ff;
         rsp_fov_ff  <= fov_ff;
         rsp_dist_ff <= dist_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_pos_z       = rsp_z_ff;
   assign rsp_view_angle  = rsp_fov_ff;
   assign rsp_orbit_range = rsp_dist_ff;

   // ------------------------------------------------------------ assertions
   // one transaction in flight: the sequencer leaves idle right after accepting
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while sequencer busy");

   // angles always kept wrapped
   a_angles_wrapped: assert property (@(posedge clock) disable iff (reset)
      yaw_ff >= -9'sd180 && yaw_ff <= 9'sd179 && pitch_ff >= -9'sd180 && pitch_ff <= 9'sd179)
      else $error("yaw or pitch out of range");

   // zoom lands inside the distance window when the window is sane
   a_zoom_clamped: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode == ocp_pkg::MODE_ZOOM && min_dist_ff <= max_dist_ff && !csr_wr_en
      |=> dist_ff >= $past(min_dist_ff) && dist_ff <= $past(max_dist_ff))
      else $error("zoom result outside distance window");

   // loading the output register always raises valid
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> rsp_valid)
      else $error("response load lost");

endmodule

// ===== rtl/core/ocp_sequencer.sv =====
// ----------------------------------------------------------------------------
// ocp_sequencer
// Step counter over the microcode table with conditional jumps on input
// and output handshake status.
// ----------------------------------------------------------------------------
module ocp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  ocp_pkg::ocp_status_type status,
   output ocp_pkg::ocp_uword_type  ctrl
);

   logic [ocp_pkg::STEP_W-1:0] step_ff;
   logic [ocp_pkg::STEP_W-1:0] step_in;
   logic                       take_jump;

   always_comb begin
      ctrl = ocp_pkg::ucode(step_ff);
   end

   always_comb begin
      case (ctrl.jump)
         ocp_pkg::JMP_NEVER:    take_jump = 1'b0;
         ocp_pkg::JMP_ALWAYS:   take_jump = 1'b1;
         ocp_pkg::JMP_NO_REQ:   take_jump = !status.req_valid;
         ocp_pkg::JMP_OUT_BUSY: take_jump = status.out_busy;
         default:               take_jump = 1'b0;
      endcase
      step_in = take_jump ? ctrl.jump_step : ctrl.next_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ocp_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for orbit_camera_position. A queue-fed driver sends
// camera commands with random gaps. A command-level model of the camera state
// predicts every position transaction, and the monitor compares each one
// field by field. Response stalls are random. Several register settings are
// covered, including the extremes and a minimum distance above the maximum.
// ----------------------------------------------------------------------------
module tb_top;
   import ocp_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int TRIG_GROW = (TRIG_FRAC_BITS >= 15) ? TRIG_FRAC_BITS - 15 : 0;
   localparam int TRIG_SHRINK = (TRIG_FRAC_BITS < 15) ? 15 - TRIG_FRAC_BITS : 1;

   // codes the block treats as no-ops
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic signed [DX_W-1:0]    dx;
      logic signed [DY_W-1:0]    dy;
      logic signed [WHEEL_W-1:0] wheel;
      int unsigned               gap;
   } camera_cmd_type;

   typedef struct {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [FOV_W-1:0]        view;
      logic [DIST_W-1:0]       orbit_range;
   } camera_pose_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [MODE_W-1:0]             req_mode = '0;
   logic signed [DX_W-1:0]        req_dx = '0;
   logic signed [DY_W-1:0]        req_dy = '0;
   logic signed [WHEEL_W-1:0]     req_wheel = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [POS_W-1:0]       rsp_pos_x;
   logic signed [POS_W-1:0]       rsp_pos_y;
   logic signed [POS_W-1:0]       rsp_pos_z;
   logic [FOV_W-1:0]              rsp_view_angle;
   logic [DIST_W-1:0]             rsp_orbit_range;

   orbit_camera_position i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_dx          (req_dx),
      .req_dy          (req_dy),
      .req_wheel       (req_wheel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_view_angle  (rsp_view_angle),
      .rsp_orbit_range (rsp_orbit_range)
   );

   camera_cmd_type  pending_cmds[$];
   camera_pose_type expected_poses[$];

   int unsigned cycles;
   int unsigned mismatches;
   int unsigned poses_checked;
   int unsigned settings_used;
   int unsigned mode_hits[8];
   logic        req_took;
   logic        rsp_took;

   // camera model state and its register copy
   int yaw_now, pitch_now, fov_now, dist_now;
   bit up_y, clamp_pitch;
   int min_d, max_d, start_yaw_deg, start_pitch_deg, start_d, fov_limit;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d positions outstanding", cycles,
                  expected_poses.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int wrap_angle(int a);
      int r;
      r = (a + 180) % 360;
      if (r < 0) r += 360;
      return r - 180;
   endfunction

   function automatic longint sine_of(int a);
      int     r;
      bit     neg;
      longint mag;
      r = (a % 360 + 360) % 360;
      neg = (r >= 180);
      if (neg) r -= 180;
      if (r > 90) r = 180 - r;
      mag = longint'(SIN_Q15[r]);
      if (TRIG_FRAC_BITS >= 15)
         mag = mag <<< TRIG_GROW;
      else
         mag = (mag + (64'sd1 <<< (TRIG_SHRINK - 1))) >>> TRIG_SHRINK;
      return neg ? -mag : mag;
   endfunction

   // arithmetic shift of the signed product is a floor
   function automatic longint floor_prod(longint a, longint b);
      return (a * b) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic void reset_camera();
      up_y = 1'b1;
      clamp_pitch = 1'b1;
      min_d = 1 << DIST_FRAC_BITS;
      max_d = 1500 << DIST_FRAC_BITS;
      start_yaw_deg = 0;
      start_pitch_deg = 90;
      start_d = 10 << DIST_FRAC_BITS;
      fov_limit = 45;
      yaw_now = 0;
      pitch_now = 90;
      dist_now = 10 << DIST_FRAC_BITS;
      fov_now = 45;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_UP_IS_Y:      up_y = data[0];
         CSR_CONSTRAIN:    clamp_pitch = data[0];
         CSR_MIN_DISTANCE: min_d = int'(data[DIST_W-1:0]);
         CSR_MAX_DISTANCE: max_d = int'(data[DIST_W-1:0]);
         CSR_START_YAW:    start_yaw_deg = int'($signed(data[ANG_W-1:0]));
         CSR_START_PITCH:  start_pitch_deg = int'($signed(data[ANG_W-1:0]));
         CSR_START_DIST:   start_d = int'(data[DIST_W-1:0]);
         CSR_MAX_FOV:      fov_limit = int'(data[FOV_W-1:0]);
         default: ;
      endcase
   endfunction

   // applies one command to the camera state and returns the new position
   function automatic camera_pose_type orbit_update(camera_cmd_type c);
      int              dx, dy, wheel, p, f;
      longint          v, d, sy, cy, sp, cp, px, py, pz;
      camera_pose_type r;
      dx = int'(c.dx);
      dy = int'(c.dy);
      wheel = int'(c.wheel);
      case (c.mode)
         MODE_ROTATE: begin
            if (up_y) begin
               p = pitch_now - dy;
               yaw_now = wrap_angle(yaw_now - dx);
               if (clamp_pitch) begin
                  if (p < PITCH_LO) p = PITCH_LO;
                  if (p > PITCH_HI) p = PITCH_HI;
               end
               pitch_now = wrap_angle(p);
            end else begin
               yaw_now = wrap_angle(yaw_now + dy);
               pitch_now = wrap_angle(pitch_now + dx);
            end
         end
         MODE_ZOOM: begin
            v = longint'(dist_now) + longint'(dy) * (64'sd1 <<< DIST_FRAC_BITS);
            if (v < min_d) v = min_d;
            if (v > max_d) v = max_d;
            if (v < 0) v = 0;
            if (v > longint'(DIST_MASK)) v = longint'(DIST_MASK);
            dist_now = int'(v);
         end
         MODE_FOV: begin
            f = fov_now;
            if (wheel != 0 && f >= 1 && f <= fov_limit) f -= wheel;
            if (f < 1) f = 1;
            else if (f > fov_limit) f = fov_limit;
            fov_now = f;
         end
         MODE_INVERT: pitch_now = wrap_angle(-pitch_now);
         MODE_START: begin
            yaw_now = wrap_angle(start_yaw_deg);
            pitch_now = wrap_angle(start_pitch_deg);
            dist_now = start_d;
            fov_now = fov_limit;
         end
         default: ;
      endcase
      d = longint'(dist_now);
      sy = sine_of(yaw_now);
      cy = sine_of(yaw_now + 90);
      sp = sine_of(pitch_now);
      cp = sine_of(pitch_now + 90);
      if (up_y) begin
         px = floor_prod(floor_prod(d, sp), sy);
         py = floor_prod(d, cp);
         pz = floor_prod(floor_prod(d, sp), cy);
      end else begin
         px = floor_prod(floor_prod(d, cy), sp);
         py = floor_prod(floor_prod(d, cy), cp);
         pz = floor_prod(d, sy);
      end
      r.pos_x = px[POS_W-1:0];
      r.pos_y = py[POS_W-1:0];
      r.pos_z = pz[POS_W-1:0];
      r.view = fov_now[FOV_W-1:0];
      r.orbit_range = dist_now[DIST_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string what, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("position %0d: %s expected %0d, got %0d", poses_checked, what, want, got);
      end
   endfunction

   // driver: one transaction per pending command, after its gap
   int unsigned gap_left;
   bit          gap_loaded;
   always @(negedge clock) begin
      camera_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // held until accepted
      end else if (pending_cmds.size() == 0) begin
         req_valid <= 1'b0;
      end else begin
         if (!gap_loaded) begin
            gap_left = pending_cmds[0].gap;
            gap_loaded = 1'b1;
         end
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else begin
            nxt = pending_cmds.pop_front();
            req_mode <= nxt.mode;
            req_dx <= nxt.dx;
            req_dy <= nxt.dy;
            req_wheel <= nxt.wheel;
            req_valid <= 1'b1;
            gap_loaded = 1'b0;
         end
      end
   end

   // response stall: a fresh draw after each accepted transaction, spent only while
   // a transaction is offered; calm stretches now and then
   int unsigned stall_left;
   bit          rsp_calm;
   always @(negedge clock) begin
      if (rsp_took) begin
         if ($urandom_range(39, 0) == 0) rsp_calm = !rsp_calm;
         stall_left = rsp_calm ? 0 : $urandom_range(4, 0);
      end
      if (rsp_valid && stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predicts on every accepted command, checks every accepted position
   always @(posedge clock) begin
      camera_cmd_type  c;
      camera_pose_type want;
      if (reset) begin
         reset_camera();
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
         if (csr_wr_en) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            c.mode = req_mode;
            c.dx = req_dx;
            c.dy = req_dy;
            c.wheel = req_wheel;
            c.gap = 0;
            mode_hits[req_mode]++;
            expected_poses.push_back(orbit_update(c));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected position x %0d y %0d z %0d fov %0d dist %0d",
                           rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_view_angle,
                           rsp_orbit_range);
            end else begin
               want = expected_poses.pop_front();
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("pos_z", want.pos_z, rsp_pos_z);
               check_field("view_angle", want.view, rsp_view_angle);
               check_field("orbit_range", want.orbit_range, rsp_orbit_range);
            end
            poses_checked++;
         end
      end
   end

   task automatic queue_cmd(logic [MODE_W-1:0] m, int x, int y, int w);
      camera_cmd_type c;
      c.mode = m;
      c.dx = DX_W'(x);
      c.dy = DY_W'(y);
      c.wheel = WHEEL_W'(w);
      c.gap = $urandom_range(4, 0);
      pending_cmds.push_back(c);
   endtask

   task automatic queue_random(int n);
      camera_cmd_type c;
      bit             calm;
      int unsigned    pick;
      calm = 1'b0;
      repeat (n) begin
         if ($urandom_range(49, 0) == 0) calm = !calm;
         pick = $urandom_range(99, 0);
         if (pick < 40) c.mode = MODE_ROTATE;
         else if (pick < 60) c.mode = MODE_ZOOM;
         else if (pick < 78) c.mode = MODE_FOV;
         else if (pick < 87) c.mode = MODE_INVERT;
         else if (pick < 96) c.mode = MODE_START;
         else if (pick < 97) c.mode = MODE_SPARE_A;
         else if (pick < 98) c.mode = MODE_SPARE_B;
         else c.mode = MODE_SPARE_C;
         // mostly small mouse moves, some anywhere in the field
         c.dx = ($urandom_range(3, 0) == 0) ? DX_W'($urandom) : DX_W'($urandom_range(60, 0) - 30);
         c.dy = ($urandom_range(3, 0) == 0) ? DY_W'($urandom) : DY_W'($urandom_range(60, 0) - 30);
         case ($urandom_range(3, 0))
            0: c.wheel = '0;
            1: c.wheel = WHEEL_W'($urandom_range(358, 0) - 179);
            default: c.wheel = WHEEL_W'($urandom_range(20, 0) - 10);
         endcase
         c.gap = calm ? 0 : $urandom_range(4, 0);
         pending_cmds.push_back(c);
      end
   endtask

   // sender and receiver both quiet, every position back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_poses.size() != 0);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic load_settings(bit up, bit con, int mn, int mx, int sy, int sp, int sd,
                                int mf);
      csr_write(CSR_UP_IS_Y, CSR_DATA_W'(up));
      csr_write(CSR_CONSTRAIN, CSR_DATA_W'(con));
      csr_write(CSR_MIN_DISTANCE, CSR_DATA_W'(mn));
      csr_write(CSR_MAX_DISTANCE, CSR_DATA_W'(mx));
      csr_write(CSR_START_YAW, CSR_DATA_W'(sy));
      csr_write(CSR_START_PITCH, CSR_DATA_W'(sp));
      csr_write(CSR_START_DIST, CSR_DATA_W'(sd));
      csr_write(CSR_MAX_FOV, CSR_DATA_W'(mf));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int mn;
      settings_used = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: clamps, zoom limits, fov limits, no-op codes
      queue_cmd(MODE_ROTATE, 0, 0, 0);
      queue_cmd(MODE_ROTATE, 2047, 2047, 0);
      queue_cmd(MODE_ROTATE, -2048, -2048, 0);
      queue_cmd(MODE_ZOOM, 0, 2047, 0);
      queue_cmd(MODE_ZOOM, 0, -2048, 0);
      queue_cmd(MODE_ZOOM, 0, 0, 0);
      queue_cmd(MODE_FOV, 0, 0, 179);
      queue_cmd(MODE_FOV, 0, 0, -179);
      queue_cmd(MODE_FOV, 0, 0, 0);
      queue_cmd(MODE_FOV, 0, 0, 1);
      queue_cmd(MODE_FOV, 0, 0, -1);
      queue_cmd(MODE_INVERT, 0, 0, 0);
      queue_cmd(MODE_INVERT, 0, 0, 0);
      queue_cmd(MODE_START, 0, 0, 0);
      queue_cmd(MODE_SPARE_A, 2047, -2048, -179);
      queue_cmd(MODE_SPARE_B, -1, 1, 179);
      queue_cmd(MODE_SPARE_C, 0, 0, 0);
      queue_random(RANDOM_PER_PHASE - 20);
      wait_drained();

      // z up, widest distance window, farthest start
      load_settings(1'b0, 1'b0, 0, DIST_MASK, -180, 179, DIST_MASK, 179);
      queue_cmd(MODE_START, 0, 0, 0);
      queue_cmd(MODE_ROTATE, 1, 0, 0);
      queue_cmd(MODE_INVERT, 0, 0, 0);
      queue_cmd(MODE_ROTATE, 2047, -2048, 0);
      queue_cmd(MODE_ZOOM, 0, 2047, 0);
      queue_cmd(MODE_FOV, 0, 0, -179);
      queue_random(RANDOM_PER_PHASE);
      wait_drained();

      // y up without pitch clamp, min above max, zero start distance, narrowest fov
      load_settings(1'b1, 1'b0, 5000, 3000, 179, -180, 0, 1);
      queue_cmd(MODE_START, 0, 0, 0);
      queue_cmd(MODE_INVERT, 0, 0, 0);
      queue_cmd(MODE_ROTATE, -2048, 2047, 0);
      queue_cmd(MODE_ZOOM, 0, -2048, 0);
      queue_cmd(MODE_FOV, 0, 0, 5);
      queue_random(RANDOM_PER_PHASE);
      wait_drained();

      // random settings, with a full drain midway
      mn = $urandom_range(20000, 0);
      load_settings(1'($urandom), 1'b1, mn, $urandom_range(DIST_MASK, 1000),
                    int'($urandom_range(359, 0)) - 180, int'($urandom_range(359, 0)) - 180,
                    $urandom_range(DIST_MASK, 0), $urandom_range(179, 1));
      queue_cmd(MODE_START, 0, 0, 0);
      queue_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      queue_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_poses.size() != 0) mismatches++;
      $display("%0d camera commands under %0d register settings: rotate %0d, zoom %0d,",
               mode_hits[MODE_ROTATE] + mode_hits[MODE_ZOOM] + mode_hits[MODE_FOV] +
               mode_hits[MODE_INVERT] + mode_hits[MODE_START] + mode_hits[MODE_SPARE_A] +
               mode_hits[MODE_SPARE_B] + mode_hits[MODE_SPARE_C], settings_used,
               mode_hits[MODE_ROTATE], mode_hits[MODE_ZOOM]);
      $display("fov %0d, invert %0d, start %0d, no-op %0d; %0d positions checked, %0d mismatches",
               mode_hits[MODE_FOV], mode_hits[MODE_INVERT], mode_hits[MODE_START],
               mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B] + mode_hits[MODE_SPARE_C],
               poses_checked, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
